### sv/hs_pkg.sv
`timescale 1ns / 1ps
// Shared sizes and types for the heap sorter.
package hs_pkg;

  localparam int DEPTH = 64;
  localparam int DW    = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = AW + 2;

  typedef logic signed [DW-1:0] data_t;
  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic [IW-1:0]        idx_t;

endpackage

### sv/hs_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for heap sorter input items and sorted results.
interface hs_in_if;
  logic            valid;
  logic            ready;
  hs_pkg::data_t   value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface hs_out_if;
  logic            valid;
  logic            ready;
  hs_pkg::data_t   sorted_value;
  logic            final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

### sv/heap_sorter_unit.sv
`timescale 1ns / 1ps
// Heap sorter top level: load store, heap build/sort sequencer, result stage.
//
// Loading: one input beat per cycle while idle; a beat with last closes the set.
// Sorting: the sequencer reuses one signed comparator and the store's single
// read port; each sift-down level steps through left read, right read,
// compare and move, and each extraction adds a root/last swap before the
// next sift-down from the root.
// Output: each result beat is read, then loaded once the result register is free.
// Reset (synchronous, rst high) clears the count and the sequencer; the store
// keeps its contents and is never read beyond what the current set wrote.
module heap_sorter_unit (
  input  logic            clk,
  input  logic            rst,
  hs_in_if.sink           items,
  hs_out_if.source        results
);

  // Sequencer state codes
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_BLD     = 4'd1;
  localparam logic [3:0] ST_BLD_CAP = 4'd2;
  localparam logic [3:0] ST_LREQ    = 4'd3;
  localparam logic [3:0] ST_RREQ    = 4'd4;
  localparam logic [3:0] ST_RCMP    = 4'd5;
  localparam logic [3:0] ST_MOVE    = 4'd6;
  localparam logic [3:0] ST_SW_A    = 4'd7;
  localparam logic [3:0] ST_SW_B    = 4'd8;
  localparam logic [3:0] ST_SW_C    = 4'd9;
  localparam logic [3:0] ST_EM_RD   = 4'd10;
  localparam logic [3:0] ST_EM_LD   = 4'd11;

  logic [3:0]    state;
  hs_pkg::cnt_t  count;     // values stored in the open set
  hs_pkg::cnt_t  n;         // size of the set being sorted
  hs_pkg::cnt_t  k;         // build: parents left; sort: live heap size
  hs_pkg::cnt_t  size;      // heap size of the current sift-down
  hs_pkg::cnt_t  e;         // emit pointer
  hs_pkg::addr_t node;      // hole position of the current sift-down
  hs_pkg::data_t val;       // value being sifted
  hs_pkg::data_t best;      // largest of val and children seen so far
  hs_pkg::idx_t  best_idx;
  logic          take;      // a child beats val
  logic          bld;       // in the heap build phase

  logic          out_valid;
  hs_pkg::data_t out_value;
  logic          out_final;

  // Store port signals
  logic          we;
  hs_pkg::addr_t waddr;
  hs_pkg::data_t wdata;
  hs_pkg::addr_t raddr;
  hs_pkg::data_t rdata;

  // Derived values
  hs_pkg::idx_t  lc;
  hs_pkg::idx_t  rc;
  hs_pkg::cnt_t  k_m1;
  hs_pkg::cnt_t  cnt_new;
  logic          lc_ok;
  logic          rc_ok;
  logic          cmp_gt;
  hs_pkg::data_t cmp_b;
  logic          load_ok;
  logic          room;
  logic          accept;

  hs_ram #(
    .WIDTH (hs_pkg::DW),
    .DEPTH (hs_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign items.ready          = (state == ST_IDLE);
  assign accept               = items.valid && items.ready;
  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.final_res    = out_final;

  always_comb begin
    lc      = {1'b0, node, 1'b1};
    rc      = lc + hs_pkg::idx_t'(1);
    k_m1    = k - hs_pkg::cnt_t'(1);
    lc_ok   = lc < hs_pkg::idx_t'(size);
    rc_ok   = rc < hs_pkg::idx_t'(size);
    room    = count < hs_pkg::cnt_t'(hs_pkg::DEPTH);
    cnt_new = room ? count + hs_pkg::cnt_t'(1) : count;
    load_ok = !out_valid || results.ready;
    // The one comparator: left child against val, then right child against
    // the winner so far.
    cmp_b   = (state == ST_RCMP) ? best : val;
    cmp_gt  = rdata > cmp_b;

    we    = 1'b0;
    waddr = node;
    wdata = val;
    raddr = node;
    unique case (state)
      ST_IDLE: begin
        we    = accept && room;
        waddr = count[hs_pkg::AW-1:0];
        wdata = items.value;
      end
      ST_BLD:     raddr = k_m1[hs_pkg::AW-1:0];
      ST_BLD_CAP: raddr = node;
      ST_LREQ: begin
        raddr = lc[hs_pkg::AW-1:0];
        we    = !lc_ok;           // leaf reached: drop val into the hole
      end
      ST_RREQ:    raddr = rc[hs_pkg::AW-1:0];
      ST_RCMP:    raddr = node;
      ST_MOVE: begin
        we    = 1'b1;             // child moves up, or val settles here
        wdata = take ? best : val;
      end
      ST_SW_A:    raddr = k_m1[hs_pkg::AW-1:0];
      ST_SW_B:    raddr = '0;
      ST_SW_C: begin
        // old root goes to the freed tail slot
        we    = 1'b1;
        waddr = k_m1[hs_pkg::AW-1:0];
        wdata = rdata;
      end
      ST_EM_RD, ST_EM_LD: raddr = e[hs_pkg::AW-1:0];
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      bld   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (items.last) begin
              n     <= cnt_new;
              k     <= cnt_new >> 1;
              count <= '0;
              bld   <= 1'b1;
              state <= ST_BLD;
            end else begin
              count <= cnt_new;
            end
          end
        end
        ST_BLD: begin
          if (k == '0) begin
            bld   <= 1'b0;
            k     <= n;
            state <= ST_SW_A;
          end else begin
            size  <= n;
            node  <= k_m1[hs_pkg::AW-1:0];
            state <= ST_BLD_CAP;
          end
        end
        ST_BLD_CAP: begin
          val   <= rdata;
          state <= ST_LREQ;
        end
        ST_LREQ: begin
          if (!lc_ok) begin
            k     <= k_m1;
            state <= bld ? ST_BLD : ST_SW_A;
          end else begin
            state <= ST_RREQ;
          end
        end
        ST_RREQ: begin
          if (cmp_gt) begin
            best     <= rdata;
            best_idx <= lc;
            take     <= 1'b1;
          end else begin
            best     <= val;
            take     <= 1'b0;
          end
          state <= rc_ok ? ST_RCMP : ST_MOVE;
        end
        ST_RCMP: begin
          if (cmp_gt) begin
            best     <= rdata;
            best_idx <= rc;
            take     <= 1'b1;
          end
          state <= ST_MOVE;
        end
        ST_MOVE: begin
          if (take) begin
            node  <= best_idx[hs_pkg::AW-1:0];
            state <= ST_LREQ;
          end else begin
            k     <= k_m1;
            state <= bld ? ST_BLD : ST_SW_A;
          end
        end
        ST_SW_A: begin
          if (k > hs_pkg::cnt_t'(1)) begin
            state <= ST_SW_B;
          end else begin
            e     <= '0;
            state <= ST_EM_RD;
          end
        end
        ST_SW_B: begin
          val   <= rdata;
          state <= ST_SW_C;
        end
        ST_SW_C: begin
          node  <= '0;
          size  <= k_m1;
          state <= ST_LREQ;
        end
        ST_EM_RD: state <= ST_EM_LD;
        ST_EM_LD: begin
          if (load_ok) begin
            if (e == n - hs_pkg::cnt_t'(1)) begin
              state <= ST_IDLE;
            end else begin
              e     <= e + hs_pkg::cnt_t'(1);
              state <= ST_EM_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register: load a beat when the slot is free, clear it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EM_LD && load_ok) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EM_LD && load_ok) begin
      out_value <= rdata;
      out_final <= (e == n - hs_pkg::cnt_t'(1));
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hs_pkg::cnt_t'(hs_pkg::DEPTH))
    else $error("element count above store depth");

  a_move_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |-> (hs_pkg::idx_t'(node) < hs_pkg::idx_t'(size)))
    else $error("sift-down write outside live heap");

  a_size_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LREQ) |-> (size != '0 && size <= n))
    else $error("sift-down heap size out of range");

  a_load_only_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EM_LD))
    else $error("result beat raised outside emit");
`endif

endmodule

### sv/hs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/heap_sorter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for heap_sorter_unit: random and directed sets, sorted results.
module heap_sorter_unit_test;

  // Cycles without any beat before the run is declared hung. The worst gap is
  // a full store being sorted on top of a long result hold-off, so this leaves
  // ample headroom.
  localparam int HANG_LIMIT = 20000;
  // Random items to send before the stimulus stops.
  localparam int RAND_ITEMS = 76;
  // Random items at the tail of the run sent with no idling on either side.
  localparam int CALM_TAIL  = 25;
  // Result count at which the receiver starts its long hold-off.
  localparam int HOLD_AT    = 30;
  localparam int HOLD_LEN   = 400;
  // Quiet cycles after the last expected result, to catch stray beats.
  localparam int DRAIN      = 200;
  localparam int DIR_ROWS   = 24;

  localparam hs_pkg::data_t MAX_VAL = 32'sh7fff_ffff;
  localparam hs_pkg::data_t MIN_VAL = 32'sh8000_0000;

  typedef struct packed {
    hs_pkg::data_t sorted_value;
    logic          final_res;
  } sorted_beat_t;

  // One row of the directed table. Rows with has_want set close a one-value
  // set whose single result is typed in; all others go through the predictor.
  typedef struct packed {
    hs_pkg::data_t value;
    logic          last;
    logic          has_want;
    hs_pkg::data_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  hs_in_if  items_ch ();
  hs_out_if results_ch ();

  heap_sorter_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: values of the set still open, in arrival order.
  hs_pkg::data_t open_set [hs_pkg::DEPTH];
  int unsigned   open_count;
  sorted_beat_t  fresh_sorted [$];
  sorted_beat_t  pending_sorted [$];

  int unsigned fails;
  int unsigned beats_seen;
  int unsigned hang_cycles;
  bit          calm;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // One-value sets at the extremes, at zero and minus one, and on alternating bit patterns.
    '{MIN_VAL,        1'b1, 1'b1, MIN_VAL},
    '{MAX_VAL,        1'b1, 1'b1, MAX_VAL},
    '{32'sd0,         1'b1, 1'b1, 32'sd0},
    '{-32'sd1,        1'b1, 1'b1, -32'sd1},
    '{32'sh5555_5555, 1'b1, 1'b1, 32'sh5555_5555},
    '{32'shaaaa_aaaa, 1'b1, 1'b1, 32'shaaaa_aaaa},
    // Mixed set with both extremes twice and equal values.
    '{MAX_VAL,        1'b0, 1'b0, 32'sd0},
    '{MIN_VAL,        1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{-32'sd5,        1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{32'sd0,         1'b0, 1'b0, 32'sd0},
    '{MAX_VAL,        1'b0, 1'b0, 32'sd0},
    '{MIN_VAL,        1'b1, 1'b0, 32'sd0},
    // Set already in ascending order.
    '{32'sd1,         1'b0, 1'b0, 32'sd0},
    '{32'sd2,         1'b0, 1'b0, 32'sd0},
    '{32'sd3,         1'b0, 1'b0, 32'sd0},
    '{32'sd4,         1'b1, 1'b0, 32'sd0},
    // Set in descending order.
    '{32'sd4,         1'b0, 1'b0, 32'sd0},
    '{32'sd3,         1'b0, 1'b0, 32'sd0},
    '{32'sd2,         1'b0, 1'b0, 32'sd0},
    '{32'sd1,         1'b1, 1'b0, 32'sd0},
    // Two equal values.
    '{-32'sd7,        1'b0, 1'b0, 32'sd0},
    '{-32'sd7,        1'b1, 1'b0, 32'sd0}
  };

  // Store one accepted value; on a closing beat, sort the open set into
  // fresh_sorted (ascending, final flag on the largest) and empty the set.
  // Values past the store depth are dropped, but their last flag still counts.
  function automatic void load_value(hs_pkg::data_t v, logic l);
    int   vals [hs_pkg::DEPTH];
    int   key;
    int   j;
    fresh_sorted.delete();
    if (open_count < hs_pkg::DEPTH) begin
      open_set[open_count] = v;
      open_count++;
    end
    if (!l) return;
    for (int i = 0; i < open_count; i++) begin
      key = open_set[i];
      j   = i - 1;
      while (j >= 0 && vals[j] > key) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = key;
    end
    for (int i = 0; i < open_count; i++) begin
      fresh_sorted.push_back('{hs_pkg::data_t'(vals[i]), (i == open_count - 1)});
    end
    open_count = 0;
  endfunction

  // Offer one beat, hold it until accepted, then record what it should
  // produce. A random idle burst may come first unless the run is calm.
  task automatic send_item(hs_pkg::data_t v, logic l, logic has_want, hs_pkg::data_t want);
    if (!calm && $urandom_range(0, 5) == 0) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.value <= v;
    items_ch.last  <= l;
    do @(posedge clk); while (!items_ch.ready);
    load_value(v, l);
    // A typed-in row replaces the predicted result of its one-value set.
    if (has_want) begin
      fresh_sorted.delete();
      fresh_sorted.push_back('{want, 1'b1});
    end
    foreach (fresh_sorted[i]) pending_sorted.push_back(fresh_sorted[i]);
  endtask

  // Stimulus: reset, directed table, then random sets with one oversized set.
  initial begin
    int unsigned   sent;
    int unsigned   set_len;
    bit            big_done;
    hs_pkg::data_t v;
    clk              = 1'b0;
    rst              = 1'b1;
    items_ch.valid   = 1'b0;
    items_ch.value   = '0;
    items_ch.last    = 1'b0;
    open_count       = 0;
    fails            = 0;
    calm             = 1'b0;
    sent             = 0;
    big_done         = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].value, dir_rows[i].last, dir_rows[i].has_want, dir_rows[i].want);
    end

    // Mostly short sets; once, a set longer than the store so that the tail
    // is dropped and the closing flag lands on a dropped beat.
    while (sent < RAND_ITEMS) begin
      if (!big_done && sent >= 10) begin
        set_len  = hs_pkg::DEPTH + $urandom_range(1, 3);
        big_done = 1'b1;
      end else begin
        set_len = $urandom_range(1, 10);
      end
      for (int i = 0; i < set_len; i++) begin
        calm = (sent + CALM_TAIL >= RAND_ITEMS);
        case ($urandom_range(0, 3))
          0: v = hs_pkg::data_t'($urandom_range(0, 8)) - 32'sd4;  // near zero, many equals
          1: v = ($urandom_range(0, 1) != 0)
                 ? MAX_VAL - hs_pkg::data_t'($urandom_range(0, 2))
                 : MIN_VAL + hs_pkg::data_t'($urandom_range(0, 2));
          default: v = hs_pkg::data_t'($urandom());
        endcase
        send_item(v, (i == set_len - 1), 1'b0, 32'sd0);
        sent++;
      end
    end
    items_ch.valid <= 1'b0;

    // Wait out every expected result, then watch for strays.
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side ready: random stall bursts, one long hold-off once enough
  // results have come so the block backs up into its input, and no stalls
  // during the calm tail.
  initial begin
    bit hold_done;
    hold_done        = 1'b0;
    results_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && beats_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        results_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      results_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    sorted_beat_t exp_beat;
    if (rst) begin
      beats_seen <= 0;
    end else if (results_ch.valid && results_ch.ready) begin
      beats_seen <= beats_seen + 1;
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: sorted_value %0d final_res %0b",
               results_ch.sorted_value, results_ch.final_res);
        fails++;
      end else begin
        exp_beat = pending_sorted.pop_front();
        if (results_ch.sorted_value !== exp_beat.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 exp_beat.sorted_value, results_ch.sorted_value);
          fails++;
        end
        if (results_ch.final_res !== exp_beat.final_res) begin
          $error("final_res: expected %0b, got %0b",
                 exp_beat.final_res, results_ch.final_res);
          fails++;
        end
      end
    end
  end

  // Hang guard: count cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles + 1 >= HANG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

### filelist.f
sv/hs_pkg.sv
sv/hs_if.sv
sv/hs_ram.sv
sv/heap_sorter_unit.sv
bench/heap_sorter_unit_test.sv
